// ===== rtl/core/bba_pkg.sv =====
// Package for the buddy block allocator: sizes, codes and shared types.
// Used by the channel interfaces, the cell, the top level and the checker.
package bba_pkg;

   localparam int MAX_BLOCKS = 32;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int COUNT_W    = 6;
   localparam int OWNER_W    = 16;
   localparam int ORDER_W    = 5;
   localparam int SIZE_W     = 31;
   localparam int STATUS_W   = 2;

   localparam logic [ORDER_W-1:0] RESET_TOTAL_ORDER = ORDER_W'(5);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NO_FIT = 2'd1,
      STATUS_FULL   = 2'd2
   } bba_status_type;

   typedef enum logic {
      OPC_ALLOC = 1'b0,
      OPC_QUERY = 1'b1
   } bba_opcode_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INIT,
      CELL_ROTATE,
      CELL_SPLIT,
      CELL_CLAIM
   } bba_cell_op_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [ORDER_W-1:0] order;
   } bba_entry_type;

   typedef struct packed {
      bba_cell_op_type    op;
      logic [IDX_W-1:0]   pos;
      logic [OWNER_W-1:0] owner;
      logic [ORDER_W-1:0] init_order;
   } bba_cmd_type;

endpackage

// ===== rtl/core/bba_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [bba_pkg::OWNER_W-1:0]  owner_id;
   logic [bba_pkg::SIZE_W-1:0]   request_size;

   modport source (output valid, output opcode, output owner_id, output request_size,
                   input ready);
   modport sink   (input valid, input opcode, input owner_id, input request_size,
                   output ready);
endinterface

interface bba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::OWNER_W-1:0]   block_owner;
   logic [bba_pkg::COUNT_W-1:0]   block_count;
   logic [bba_pkg::STATUS_W-1:0]  status;
   logic                          last;

   modport source (output valid, output block_owner, output block_count, output status,
                   output last, input ready);
   modport sink   (input valid, input block_owner, input block_count, input status,
                   input last, output ready);
endinterface

// ===== rtl/core/bba_cell.sv =====
// One cell of the block table: holds a single entry (owner and order).
// Depends on bba_pkg; its neighbors feed it for rotation and for splits.
module bba_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [bba_pkg::IDX_W-1:0] cell_idx,
   input  bba_pkg::bba_cmd_type    cmd,
   input  bba_pkg::bba_entry_type  left_entry,
   input  bba_pkg::bba_entry_type  right_entry,
   output bba_pkg::bba_entry_type  entry
);
   import bba_pkg::*;

   bba_entry_type      entry_ff;
   bba_entry_type      entry_in;
   logic [IDX_W:0]     pos_next;

   assign pos_next = {1'b0, cmd.pos} + (IDX_W+1)'(1);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INIT: begin
            entry_in.owner = '0;
            entry_in.order = (cell_idx == '0) ? cmd.init_order : '0;
         end
         CELL_ROTATE: begin
            entry_in = right_entry;
         end
         CELL_SPLIT: begin
            // The split block keeps the left half; its buddy is inserted to the right.
            if (cell_idx == cmd.pos) begin
               entry_in.order = entry_ff.order - ORDER_W'(1);
            end else if ({1'b0, cell_idx} == pos_next) begin
               entry_in.owner = '0;
               entry_in.order = left_entry.order - ORDER_W'(1);
            end else if (cell_idx > cmd.pos) begin
               entry_in = left_entry;
            end
         end
         CELL_CLAIM: begin
            if (cell_idx == cmd.pos) entry_in.owner = cmd.owner;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.owner <= '0;
         entry_ff.order <= (cell_idx == '0) ? RESET_TOTAL_ORDER : '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: control sequencer and the ring of table cells.
// Depends on bba_pkg, bba_req_if / bba_rsp_if and bba_cell.
//
// Usage. Requests arrive on req_ch as valid/ready transactions. An allocate transaction
// (opcode 0) rounds request_size up to a power of two and claims the leftmost free block
// of that order, halving the leftmost larger free block as often as needed. It returns one
// response with status 0 (ok), 1 (nothing large enough) or 2 (table full), block_count
// and last set. A query transaction (opcode 1) returns one response per block in address
// order, carrying the owner, with last set on the final one.
// The table is a ring of 32 cells. Searching and querying rotate the whole ring once, one
// cell per cycle while nothing stalls, so the ring always comes back to its original place.
// After acceptance an allocate finds the order (one bit per cycle), searches the ring,
// decides, halves the chosen block as often as needed, claims it (not on failure) and
// loads the reply. One transaction is in work at a time; req_ch.ready is high only while
// the sequencer is idle. Stalls. Responses sit in an output register. While a response
// waits with rsp_ch.ready low, a query pauses its rotation and an allocate waits to load
// its reply.
// Reset. A synchronous, active-high reset leaves one free block of order 5. Writing
// csr_wr_data with csr_wr_en reloads total_order and restarts the table as one free block.
module buddy_block_allocator (
   input  logic                          clock,
   input  logic                          reset,
   bba_req_if.sink                       req_ch,
   bba_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bba_pkg::ORDER_W-1:0]   csr_wr_data
);
   import bba_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ORDER,
      ST_SEARCH,
      ST_DECIDE,
      ST_SPLIT,
      ST_CLAIM,
      ST_REPLY,
      ST_QUERY
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   live_ff;
   logic [IDX_W-1:0]     scan_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [ORDER_W-1:0]   want_ff;
   logic [OWNER_W-1:0]   owner_ff;
   logic                 eq_found_ff;
   logic                 gt_found_ff;
   logic [IDX_W-1:0]     eq_pos_ff;
   logic [IDX_W-1:0]     gt_pos_ff;
   logic [ORDER_W-1:0]   gt_order_ff;
   logic [IDX_W-1:0]     pos_ff;
   logic [ORDER_W-1:0]   split_cnt_ff;
   bba_status_type       status_ff;

   logic                 rsp_valid_ff;
   logic [OWNER_W-1:0]   rsp_owner_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   bba_status_type       rsp_status_ff;
   logic                 rsp_last_ff;

   bba_entry_type        entries [MAX_BLOCKS];
   bba_entry_type        head;
   bba_cmd_type          cell_cmd;

   logic                 rsp_free;
   logic                 rsp_load;
   logic                 scan_live;
   logic                 query_step;
   logic                 scan_end;
   logic [COUNT_W:0]     need_blocks;

   // The cell at index zero always shows the entry currently under the scan counter.
   assign head       = entries[0];
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign scan_live  = COUNT_W'(scan_ff) < live_ff;
   assign query_step = !scan_live || rsp_free;
   assign scan_end   = (scan_ff == IDX_W'(MAX_BLOCKS - 1));
   assign need_blocks = {1'b0, live_ff} + (COUNT_W+1)'(gt_order_ff - want_ff);

   // A new response is loaded into the output register in this cycle.
   assign rsp_load = rsp_free &&
                     ((state_ff == ST_REPLY) || (state_ff == ST_QUERY && scan_live));

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.block_owner = rsp_owner_ff;
   assign rsp_ch.block_count = rsp_count_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // Command broadcast to every cell; a configuration write takes precedence.
   always_comb begin
      cell_cmd.op         = CELL_HOLD;
      cell_cmd.pos        = pos_ff;
      cell_cmd.owner      = owner_ff;
      cell_cmd.init_order = csr_wr_data;
      if (csr_wr_en) begin
         cell_cmd.op = CELL_INIT;
      end else begin
         case (state_ff)
            ST_SEARCH: cell_cmd.op = CELL_ROTATE;
            ST_QUERY:  cell_cmd.op = query_step ? CELL_ROTATE : CELL_HOLD;
            ST_SPLIT:  cell_cmd.op = CELL_SPLIT;
            ST_CLAIM:  cell_cmd.op = CELL_CLAIM;
            default:   cell_cmd.op = CELL_HOLD;
         endcase
      end
   end

   // Ring of cells: each cell sees both neighbors, the ends wrap around.
   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      bba_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(g)),
         .cmd         (cell_cmd),
         .left_entry  (entries[(g + MAX_BLOCKS - 1) % MAX_BLOCKS]),
         .right_entry (entries[(g + 1) % MAX_BLOCKS]),
         .entry       (entries[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         live_ff        <= COUNT_W'(1);
         scan_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wr_en) begin
            live_ff        <= COUNT_W'(1);
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  owner_ff <= req_ch.owner_id;
                  scan_ff  <= '0;
                  if (req_ch.opcode == OPC_QUERY) begin
                     state_ff <= ST_QUERY;
                  end else begin
                     // A size of zero behaves like a size of one.
                     size_ff  <= (req_ch.request_size == '0) ? '0
                                 : req_ch.request_size - SIZE_W'(1);
                     want_ff  <= '0;
                     state_ff <= ST_ORDER;
                  end
               end
            end
            ST_ORDER: begin
               // Count significant bits of size minus one: that is the rounded-up order.
               if (size_ff == '0) begin
                  eq_found_ff <= 1'b0;
                  gt_found_ff <= 1'b0;
                  state_ff    <= ST_SEARCH;
               end else begin
                  size_ff <= size_ff >> 1;
                  want_ff <= want_ff + ORDER_W'(1);
               end
            end
            ST_SEARCH: begin
               if (scan_live && head.owner == '0) begin
                  if (head.order == want_ff && !eq_found_ff) begin
                     eq_found_ff <= 1'b1;
                     eq_pos_ff   <= scan_ff;
                  end
                  if (head.order > want_ff && !gt_found_ff) begin
                     gt_found_ff <= 1'b1;
                     gt_pos_ff   <= scan_ff;
                     gt_order_ff <= head.order;
                  end
               end
               if (scan_end) begin
                  scan_ff  <= '0;
                  state_ff <= ST_DECIDE;
               end else begin
                  scan_ff <= scan_ff + IDX_W'(1);
               end
            end
            ST_DECIDE: begin
               if (eq_found_ff) begin
                  pos_ff   <= eq_pos_ff;
                  state_ff <= ST_CLAIM;
               end else if (!gt_found_ff) begin
                  status_ff <= STATUS_NO_FIT;
                  state_ff  <= ST_REPLY;
               end else if (need_blocks > (COUNT_W+1)'(MAX_BLOCKS)) begin
                  // Every halving adds one block; refuse before touching the table.
                  status_ff <= STATUS_FULL;
                  state_ff  <= ST_REPLY;
               end else begin
                  pos_ff       <= gt_pos_ff;
                  split_cnt_ff <= gt_order_ff - want_ff;
                  state_ff     <= ST_SPLIT;
               end
            end
            ST_SPLIT: begin
               live_ff      <= live_ff + COUNT_W'(1);
               split_cnt_ff <= split_cnt_ff - ORDER_W'(1);
               if (split_cnt_ff == ORDER_W'(1)) state_ff <= ST_CLAIM;
            end
            ST_CLAIM: begin
               status_ff <= STATUS_OK;
               state_ff  <= ST_REPLY;
            end
            ST_REPLY: begin
               if (rsp_free) begin
                  rsp_owner_ff  <= '0;
                  rsp_count_ff  <= live_ff;
                  rsp_status_ff <= status_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_QUERY: begin
               if (query_step) begin
                  if (scan_live) begin
                     rsp_owner_ff  <= head.owner;
                     rsp_count_ff  <= live_ff;
                     rsp_status_ff <= STATUS_OK;
                     rsp_last_ff   <= (COUNT_W'(scan_ff) + COUNT_W'(1) == live_ff);
                  end
                  if (scan_end) begin
                     scan_ff  <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     scan_ff <= scan_ff + IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/bba_checker.sv =====
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on bba_pkg for widths and status codes.
module bba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bba_pkg::OWNER_W-1:0]   rsp_block_owner,
   input logic [bba_pkg::COUNT_W-1:0]   rsp_block_count,
   input logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_last
);
   import bba_pkg::*;

   // A failed allocate is a single transaction, so it must carry last.
   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last)
      else $error("failed allocate reply without last");

   // Failed allocate replies report owner zero.
   a_fail_owner_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_block_owner == '0)
      else $error("failed allocate reply with nonzero owner");

   // The table never becomes empty nor exceeds its capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_block_count != '0 &&
                    rsp_block_count <= COUNT_W'(MAX_BLOCKS))
      else $error("block count out of range");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_owner) &&
                                  $stable(rsp_block_count) && $stable(rsp_status) &&
                                  $stable(rsp_last))
      else $error("stalled response changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_block_owner (rsp_ch.block_owner),
   .rsp_block_count (rsp_ch.block_count),
   .rsp_status      (rsp_ch.status),
   .rsp_last        (rsp_ch.last)
);

// ===== tb/buddy_block_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the buddy block allocator. It needs bba_pkg,
// bba_req_if / bba_rsp_if and the buddy_block_allocator top level, nothing else.
module buddy_block_allocator_test;
   import bba_pkg::*;

   // The run gives up here. The slowest correct run stays well below this.
   localparam int CYCLE_LIMIT   = 800_000;
   localparam int PHASE_ITEMS   = 30;
   localparam int SETTLE_CYCLES = 120;

   // One expected response transaction.
   typedef struct {
      logic [OWNER_W-1:0] owner;
      logic [COUNT_W-1:0] count;
      bba_status_type     status;
      logic               last;
   } block_reply_type;

   // Shadow copy of the block table. Accepted requests update it and queue the
   // responses they should cause; responses from the block are checked against
   // the oldest entry of that queue.
   class block_table_board_type;
      logic [OWNER_W-1:0] owners [MAX_BLOCKS];
      int                 orders [MAX_BLOCKS];
      int                 live;
      int                 total_order;
      block_reply_type    expected_replies [$];
      int                 mismatches;

      function new();
         mismatches = 0;
         restart(RESET_TOTAL_ORDER);
      endfunction

      // Back to one free block that spans the whole memory.
      function void restart(int new_order);
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            owners[i] = '0;
            orders[i] = 0;
         end
         total_order = new_order & 31;
         orders[0]   = total_order;
         live        = 1;
      endfunction

      // Claims the leftmost free block of exactly the wanted order, splitting
      // the leftmost larger free block first when there is none.
      function bba_status_type claim_block(logic [OWNER_W-1:0] owner, int want);
         int pos;
         bit found;
         found = 1'b0;
         pos   = 0;
         for (int i = 0; i < live; i++) begin
            if (owners[i] == '0 && orders[i] == want) begin
               owners[i] = owner;
               return STATUS_OK;
            end
         end
         for (int i = 0; i < live && !found; i++) begin
            if (owners[i] == '0 && orders[i] > want) begin
               pos   = i;
               found = 1'b1;
            end
         end
         if (!found)
            return STATUS_NO_FIT;
         // The whole split must fit, otherwise the table stays as it is.
         if (live + orders[pos] - want > MAX_BLOCKS)
            return STATUS_FULL;
         while (orders[pos] > want) begin
            for (int j = live; j > pos + 1; j--) begin
               owners[j] = owners[j-1];
               orders[j] = orders[j-1];
            end
            orders[pos]   = orders[pos] - 1;
            orders[pos+1] = orders[pos];
            owners[pos+1] = '0;
            live++;
         end
         owners[pos] = owner;
         return STATUS_OK;
      endfunction

      // Notes one accepted request transaction and queues its responses.
      function void note_request(bba_opcode_type op, logic [OWNER_W-1:0] owner,
                                 logic [SIZE_W-1:0] size);
         block_reply_type reply;
         int              want;
         bba_status_type  result;
         if (op == OPC_QUERY) begin
            for (int i = 0; i < live; i++) begin
               reply.owner  = owners[i];
               reply.count  = COUNT_W'(live);
               reply.status = STATUS_OK;
               reply.last   = (i == live - 1);
               expected_replies.push_back(reply);
            end
         end else begin
            // A size of zero counts as one unit.
            want         = (size <= 1) ? 0 : $clog2(size);
            result       = claim_block(owner, want);
            reply.owner  = '0;
            reply.count  = COUNT_W'(live);
            reply.status = result;
            reply.last   = 1'b1;
            expected_replies.push_back(reply);
         end
      endfunction

      // Checks one accepted response transaction against the oldest expectation.
      function void check_reply(logic [OWNER_W-1:0] owner, logic [COUNT_W-1:0] count,
                                logic [STATUS_W-1:0] status, logic last);
         block_reply_type want;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: owner %h count %0d status %0d last %b",
                        owner, count, status, last);
            return;
         end
         want = expected_replies.pop_front();
         if (owner !== want.owner || count !== want.count ||
             status !== want.status || last !== want.last) begin
            mismatches++;
            // Fields in order: owner, count, status, last.
            if (mismatches <= 10)
               $display("response mismatch: expected %h %0d %0d %b, got %h %0d %0d %b",
                        want.owner, want.count, want.status, want.last,
                        owner, count, status, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ORDER_W-1:0] csr_wr_data;

   bba_req_if req_ch ();
   bba_rsp_if rsp_ch ();

   buddy_block_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   block_table_board_type board = new();

   // Percent of cycles in which the sender or the receiver holds back.
   int send_idle_pct = 17;
   int recv_idle_pct = 50;
   int cycle_count   = 0;
   int item_count    = 0;
   int phase_orders [11] = '{3, 30, 1, 7, 12, 5, 20, 2, 9, 16, 4};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The run is cut off once cycle_count reaches CYCLE_LIMIT, as when the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The receiver drops ready at random, one decision per clock.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every response transaction is checked at the edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         board.check_reply(rsp_ch.block_owner, rsp_ch.block_count, rsp_ch.status,
                           rsp_ch.last);
   end

   // Offers one request and returns at the edge where it is accepted. Valid is
   // left high so that back-to-back transactions need no gap.
   task automatic send_request(input bba_opcode_type op, input logic [OWNER_W-1:0] owner,
                               input logic [SIZE_W-1:0] size);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.owner_id     <= owner;
      req_ch.request_size <= size;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_request(op, owner, size);
   endtask

   // Holds the sender off until every expected response has come and the
   // sequencer is back to idle. A query may still be rotating the ring after
   // its last response, so ready is the real sign of idle.
   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      while (board.expected_replies.size() != 0 || req_ch.ready !== 1'b1)
         @(posedge clock);
   endtask

   // Rewrites total_order, which also restarts the block table.
   task automatic write_total_order(input int order);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ORDER_W'(order);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.restart(order);
   endtask

   // One random transaction. Most are allocations that can fit the current
   // memory, so the table keeps splitting until it fills up; a few are raw
   // noise over the whole size range.
   task automatic random_request();
      int unsigned        pick;
      int unsigned        order;
      int unsigned        half;
      logic [OWNER_W-1:0] owner;
      logic [SIZE_W-1:0]  size;
      pick  = $urandom_range(99);
      owner = OWNER_W'($urandom_range(1, 65535));
      if ($urandom_range(29) == 0)
         owner = '0;
      if (pick < 20) begin
         send_request(OPC_QUERY, OWNER_W'($urandom), SIZE_W'($urandom));
      end else if (pick < 90) begin
         // Small orders dominate so that large memories still fill the table.
         if ($urandom_range(1) == 0)
            order = $urandom_range(0, board.total_order);
         else
            order = $urandom_range(0, (board.total_order < 6) ? board.total_order : 6);
         if (order == 0) begin
            size = SIZE_W'($urandom_range(0, 1));
         end else begin
            half = 1 << (order - 1);
            size = SIZE_W'(half + $urandom_range(1, half));
         end
         send_request(OPC_ALLOC, owner, size);
      end else begin
         send_request(OPC_ALLOC, OWNER_W'($urandom), SIZE_W'($urandom));
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= OPC_ALLOC;
      req_ch.owner_id     <= '0;
      req_ch.request_size <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      board.restart(RESET_TOTAL_ORDER);

      // Directed part on the reset memory of 32 units. A zero size counts as
      // one unit and splits the whole memory down to order zero.
      send_request(OPC_QUERY, 16'h0000, 31'h0000_0000);
      send_request(OPC_ALLOC, 16'hFFFF, 31'h0000_0000);
      send_request(OPC_ALLOC, 16'h0001, 31'h0000_0001);
      // Owner zero claims, but the block stays free, so the next
      // request of the same order takes the very same block.
      send_request(OPC_ALLOC, 16'h0000, 31'h0000_0002);
      send_request(OPC_ALLOC, 16'h0002, 31'h0000_0002);
      // Requests larger than any free block fail; the largest size rounds up
      // to order 31, the most that the register can hold.
      send_request(OPC_ALLOC, 16'h0003, 31'h4000_0000);
      send_request(OPC_ALLOC, 16'h0004, 31'h7FFF_FFFF);
      send_request(OPC_ALLOC, 16'h0005, 31'h0000_0003);
      send_request(OPC_QUERY, 16'hFFFF, 31'h7FFF_FFFF);

      // The largest memory in this bench: unit requests split it to 31 and then 32 blocks,
      // after which a further split no longer fits the table.
      write_total_order(30);
      send_request(OPC_ALLOC, 16'h8000, 31'h0000_0001);
      send_request(OPC_ALLOC, 16'h0006, 31'h0000_0001);
      send_request(OPC_ALLOC, 16'h0007, 31'h0000_0001);
      send_request(OPC_ALLOC, 16'h0008, 31'h0000_0001);
      send_request(OPC_ALLOC, 16'h0009, 31'h0000_0001);
      send_request(OPC_ALLOC, 16'h000A, 31'h4000_0000);
      send_request(OPC_QUERY, 16'h0000, 31'h0000_0000);

      // The smallest memory holds a single unit.
      write_total_order(0);
      send_request(OPC_ALLOC, 16'h000B, 31'h0000_0002);
      send_request(OPC_ALLOC, 16'h000C, 31'h0000_0001);
      send_request(OPC_QUERY, 16'h5555, 31'h2AAA_AAAA);

      // Random part, one memory size per phase. The idling pattern changes
      // after each third of the transactions, ending with no idling at all.
      phase_orders[10] = $urandom_range(0, 30);
      for (int phase = 0; phase < 11; phase++) begin
         write_total_order(phase_orders[phase]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (item_count == 110) begin
               send_idle_pct = 50;
               recv_idle_pct = 17;
            end else if (item_count == 220) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            // Once in mid-phase the sender stops until the block has drained.
            if (item_count == 165)
               wait_until_idle();
            random_request();
            item_count++;
         end
      end

      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.expected_replies.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
